// ===== sv/pgcg_pkg.sv =====
package pgcg_pkg;

  // Field widths.
  localparam int COORD_BITS     = 32;
  localparam int TAG_BITS       = 32;
  localparam int OUT_BITS       = COORD_BITS + 2;
  localparam int NUDGE_BITS     = 16;
  localparam int NUM_REGIONS    = 9;
  localparam int REGION_BITS    = 4;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = COORD_BITS;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_BOUND = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_BOUND = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_NUDGE       = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_ALL    = CFG_INDEX_BITS'(3);

  // Register values after reset: box of -1.0 to 1.0, nudge of about 1e-4.
  localparam logic signed [COORD_BITS-1:0] UPPER_RESET = COORD_BITS'(65536);
  localparam logic signed [COORD_BITS-1:0] LOWER_RESET = -UPPER_RESET;
  localparam logic [NUDGE_BITS-1:0]        NUDGE_RESET = NUDGE_BITS'(7);

  typedef logic signed [OUT_BITS-1:0]  out_coord_t;
  typedef logic [NUM_REGIONS-1:0]      region_mask_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] upper_bound;
    logic signed [COORD_BITS-1:0] lower_bound;
    logic [NUDGE_BITS-1:0]        nudge;
    logic                         keep_all_mode;
  } cfg_t;

  // Direction of one term of a copy offset.
  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_PLUS,
    DIR_MINUS
  } dir_t;

  typedef struct packed {
    dir_t dx;
    dir_t dy;
    dir_t dn;
  } region_dir_t;

  // Shift directions in x and y and the nudge sign for each region.
  // Region 0 is the original; 1 to 8 are A to H.
  function automatic region_dir_t region_dir(input logic [REGION_BITS-1:0] r);
    region_dir_t d;
    case (r)
      4'd1:    d = '{DIR_MINUS, DIR_PLUS,  DIR_MINUS};
      4'd2:    d = '{DIR_NONE,  DIR_PLUS,  DIR_PLUS};
      4'd3:    d = '{DIR_PLUS,  DIR_PLUS,  DIR_PLUS};
      4'd4:    d = '{DIR_MINUS, DIR_NONE,  DIR_MINUS};
      4'd5:    d = '{DIR_PLUS,  DIR_NONE,  DIR_PLUS};
      4'd6:    d = '{DIR_MINUS, DIR_MINUS, DIR_MINUS};
      4'd7:    d = '{DIR_NONE,  DIR_MINUS, DIR_MINUS};
      4'd8:    d = '{DIR_PLUS,  DIR_MINUS, DIR_PLUS};
      default: d = '{DIR_NONE,  DIR_NONE,  DIR_NONE};
    endcase
    return d;
  endfunction

endpackage

// ===== sv/pgcg_if.sv =====
// Particle channel.
interface pgcg_particle_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pgcg_pkg::COORD_BITS-1:0]   pos_x;
  logic signed [pgcg_pkg::COORD_BITS-1:0]   pos_y;
  logic [pgcg_pkg::TAG_BITS-1:0]            tag;

  modport source(output valid, pos_x, pos_y, tag, input ready);
  modport sink(input valid, pos_x, pos_y, tag, output ready);
endinterface

// Ghost copy channel.
interface pgcg_ghost_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pgcg_pkg::OUT_BITS-1:0]     copy_x;
  logic signed [pgcg_pkg::OUT_BITS-1:0]     copy_y;
  logic [pgcg_pkg::TAG_BITS-1:0]            copy_tag;
  logic [pgcg_pkg::REGION_BITS-1:0]         region;
  logic                                     last;

  modport source(output valid, copy_x, copy_y, copy_tag, region, last, input ready);
  modport sink(input valid, copy_x, copy_y, copy_tag, region, last, output ready);
endinterface

// Configuration write channel.
interface pgcg_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [pgcg_pkg::CFG_INDEX_BITS-1:0]      index;
  logic [pgcg_pkg::CFG_DATA_BITS-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/pgcg_cfg_regs.sv =====
module pgcg_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  pgcg_cfg_if.sink         cfg,
  output pgcg_pkg::cfg_t   regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.upper_bound   <= pgcg_pkg::UPPER_RESET;
      regs.lower_bound   <= pgcg_pkg::LOWER_RESET;
      regs.nudge         <= pgcg_pkg::NUDGE_RESET;
      regs.keep_all_mode <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pgcg_pkg::REG_UPPER_BOUND: regs.upper_bound <= cfg.data[pgcg_pkg::COORD_BITS-1:0];
        pgcg_pkg::REG_LOWER_BOUND: regs.lower_bound <= cfg.data[pgcg_pkg::COORD_BITS-1:0];
        pgcg_pkg::REG_NUDGE:       regs.nudge       <= cfg.data[pgcg_pkg::NUDGE_BITS-1:0];
        pgcg_pkg::REG_KEEP_ALL:    regs.keep_all_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/pgcg_copy_calc.sv =====
module pgcg_copy_calc (
  input  logic signed [pgcg_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [pgcg_pkg::COORD_BITS-1:0] pos_y,
  input  pgcg_pkg::cfg_t                         regs,
  output pgcg_pkg::out_coord_t                   copy_x [pgcg_pkg::NUM_REGIONS],
  output pgcg_pkg::out_coord_t                   copy_y [pgcg_pkg::NUM_REGIONS],
  output pgcg_pkg::region_mask_t                 emit
);

  localparam int EXT = pgcg_pkg::OUT_BITS - pgcg_pkg::COORD_BITS;

  // Selects +val, -val or zero for one offset term.
  function automatic pgcg_pkg::out_coord_t term(input pgcg_pkg::dir_t d,
                                                input pgcg_pkg::out_coord_t val);
    case (d)
      pgcg_pkg::DIR_PLUS:  return val;
      pgcg_pkg::DIR_MINUS: return -val;
      default:             return '0;
    endcase
  endfunction

  pgcg_pkg::out_coord_t shift;
  pgcg_pkg::out_coord_t nd;
  pgcg_pkg::out_coord_t px;
  pgcg_pkg::out_coord_t py;
  pgcg_pkg::out_coord_t lo;
  pgcg_pkg::out_coord_t hi;

  // Operands widened to the copy width; the shift is twice the upper bound.
  always_comb begin
    shift = {{(EXT-1){regs.upper_bound[pgcg_pkg::COORD_BITS-1]}}, regs.upper_bound, 1'b0};
    nd    = {{(pgcg_pkg::OUT_BITS-pgcg_pkg::NUDGE_BITS){1'b0}}, regs.nudge};
    px    = {{EXT{pos_x[pgcg_pkg::COORD_BITS-1]}}, pos_x};
    py    = {{EXT{pos_y[pgcg_pkg::COORD_BITS-1]}}, pos_y};
    lo    = {{EXT{regs.lower_bound[pgcg_pkg::COORD_BITS-1]}}, regs.lower_bound};
    hi    = {{EXT{regs.upper_bound[pgcg_pkg::COORD_BITS-1]}}, regs.upper_bound};
  end

  // All nine copies and their box tests side by side.
  always_comb begin
    pgcg_pkg::region_dir_t d;
    for (int r = 0; r < pgcg_pkg::NUM_REGIONS; r++) begin
      d = pgcg_pkg::region_dir(pgcg_pkg::REGION_BITS'(r));
      copy_x[r] = px + term(d.dx, shift) + term(d.dn, nd);
      copy_y[r] = py + term(d.dy, shift) + term(d.dn, nd);
      emit[r]   = regs.keep_all_mode |
                  ((copy_x[r] >= lo) && (copy_x[r] <= hi) &&
                   (copy_y[r] >= lo) && (copy_y[r] <= hi));
    end
  end

endmodule

// ===== sv/pgcg_emit.sv =====
module pgcg_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load_valid,
  output logic                           load_ready,
  input  pgcg_pkg::out_coord_t           load_x [pgcg_pkg::NUM_REGIONS],
  input  pgcg_pkg::out_coord_t           load_y [pgcg_pkg::NUM_REGIONS],
  input  logic [pgcg_pkg::TAG_BITS-1:0]  load_tag,
  input  pgcg_pkg::region_mask_t         load_mask,
  pgcg_ghost_if.source                   ghost
);

  // Copy set of the particle being sent out.
  logic                                  set_valid;
  pgcg_pkg::region_mask_t                set_mask;
  pgcg_pkg::out_coord_t                  set_x [pgcg_pkg::NUM_REGIONS];
  pgcg_pkg::out_coord_t                  set_y [pgcg_pkg::NUM_REGIONS];
  logic [pgcg_pkg::TAG_BITS-1:0]         set_tag;

  logic [pgcg_pkg::REGION_BITS-1:0]      sel;
  logic                                  single;
  logic                                  out_load;
  logic                                  set_done;

  // Lowest pending region goes next.
  always_comb begin
    sel = '0;
    for (int r = pgcg_pkg::NUM_REGIONS - 1; r >= 0; r--) begin
      if (set_mask[r]) begin
        sel = pgcg_pkg::REGION_BITS'(r);
      end
    end
  end

  // The copy is the last one when only one region is still pending.
  assign single     = (set_mask & (set_mask - pgcg_pkg::region_mask_t'(1))) == '0;
  assign out_load   = set_valid && (!ghost.valid || ghost.ready);
  assign set_done   = out_load && single;
  assign load_ready = !set_valid || set_done;

  // Valid flags of the copy set and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_valid   <= 1'b0;
      ghost.valid <= 1'b0;
    end else begin
      if (load_valid && load_ready) begin
        set_valid <= 1'b1;
      end else if (set_done) begin
        set_valid <= 1'b0;
      end
      if (out_load) begin
        ghost.valid <= 1'b1;
      end else if (ghost.ready) begin
        ghost.valid <= 1'b0;
      end
    end
  end

  // Copy set payload and pending mask.
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      set_mask <= load_mask;
      set_x    <= load_x;
      set_y    <= load_y;
      set_tag  <= load_tag;
    end else if (out_load) begin
      set_mask <= set_mask & ~(pgcg_pkg::region_mask_t'(1) << sel);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      ghost.copy_x   <= set_x[sel];
      ghost.copy_y   <= set_y[sel];
      ghost.copy_tag <= set_tag;
      ghost.region   <= sel;
      ghost.last     <= single;
    end
  end

endmodule

// ===== sv/periodic_ghost_copy_generator.sv =====
// Periodic ghost copy generator. Each particle item (pos_x, pos_y, tag) yields up to nine
// ghost items, one per cycle unless the ghost channel stalls, in region order 0 to 8, with
// last set on the final one; a particle with no copy inside the box yields nothing. The
// single output register is shared by all copies: a particle holds the emitter until all
// its copies (nine in keep-all mode) are loaded, and one with no copies is dropped at once.
// A particle passes the input, copy set and output registers, and the next particle is
// taken while the current one's copies are still leaving. Configuration writes are taken
// at any time but must only be issued while the block is idle.
module periodic_ghost_copy_generator (
  input  logic              clk,
  input  logic              rst,
  pgcg_particle_if.sink     particle,
  pgcg_ghost_if.source      ghost,
  pgcg_cfg_if.sink          cfg
);

  pgcg_pkg::cfg_t                          regs;

  // Particle input register.
  logic                                    p_valid;
  logic signed [pgcg_pkg::COORD_BITS-1:0]  p_x;
  logic signed [pgcg_pkg::COORD_BITS-1:0]  p_y;
  logic [pgcg_pkg::TAG_BITS-1:0]           p_tag;

  pgcg_pkg::out_coord_t                    copy_x [pgcg_pkg::NUM_REGIONS];
  pgcg_pkg::out_coord_t                    copy_y [pgcg_pkg::NUM_REGIONS];
  pgcg_pkg::region_mask_t                  emit;
  logic                                    load_ready;
  logic                                    p_adv;

  pgcg_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pgcg_copy_calc u_calc (
    .pos_x  (p_x),
    .pos_y  (p_y),
    .regs   (regs),
    .copy_x (copy_x),
    .copy_y (copy_y),
    .emit   (emit)
  );

  pgcg_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (p_valid && (emit != '0)),
    .load_ready (load_ready),
    .load_x     (copy_x),
    .load_y     (copy_y),
    .load_tag   (p_tag),
    .load_mask  (emit),
    .ghost      (ghost)
  );

  // A particle with no copies is dropped at once; otherwise it waits for the emitter.
  assign p_adv          = p_valid && ((emit == '0) || load_ready);
  assign particle.ready = !p_valid || p_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (particle.valid && particle.ready) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (particle.valid && particle.ready) begin
      p_x   <= particle.pos_x;
      p_y   <= particle.pos_y;
      p_tag <= particle.tag;
    end
  end

endmodule

// ===== sv/pgcg_checker.sv =====
module pgcg_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [pgcg_pkg::OUT_BITS-1:0]    out_x,
  input logic signed [pgcg_pkg::OUT_BITS-1:0]    out_y,
  input logic [pgcg_pkg::TAG_BITS-1:0]           out_tag,
  input logic [pgcg_pkg::REGION_BITS-1:0]        out_region,
  input logic                                    out_last
);

  // A stalled copy holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_tag) && $stable(out_region) && $stable(out_last))
    else $error("ghost item changed while stalled");

  // Only regions 0 to 8 exist.
  a_region_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_region <= pgcg_pkg::REGION_BITS'(pgcg_pkg::NUM_REGIONS - 1))
    else $error("ghost region out of range");

  // Copies of one particle follow at once, in rising region order, with one tag.
  a_region_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_region > $past(out_region)) && (out_tag == $past(out_tag)))
    else $error("ghost copies out of order or interrupted");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("ghost item offered after reset");

endmodule

bind periodic_ghost_copy_generator pgcg_checker u_pgcg_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (ghost.valid),
  .out_ready  (ghost.ready),
  .out_x      (ghost.copy_x),
  .out_y      (ghost.copy_y),
  .out_tag    (ghost.copy_tag),
  .out_region (ghost.region),
  .out_last   (ghost.last)
);
